// ===== rtl/core/mlp_inference_tanh_sigmoid_defines.svh =====
// ----------------------------------------------------------------------------
// mlp scorer assertion macros
// shared property shorthands for the scorer core, clocked on clk, reset rst_n
// ----------------------------------------------------------------------------
`ifndef MLP_INFERENCE_TANH_SIGMOID_DEFINES_SVH
`define MLP_INFERENCE_TANH_SIGMOID_DEFINES_SVH

// same-cycle implication
`define MLP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MLP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mlp_pkg.sv =====
// ----------------------------------------------------------------------------
// mlp scorer package
// network sizes, datapath widths, weight store and tanh table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mlp_pkg;

    localparam int HIDDEN_NEURONS = 5;
    localparam int FRAC_BITS      = 12;
    localparam int NUM_FEATURES   = 4;
    localparam int FEAT_W         = 16;
    localparam int TRAINED_COUNT  = 31;
    localparam int WROM_DEPTH     = 6 * HIDDEN_NEURONS + 1;
    localparam int WIDX_W         = $clog2(WROM_DEPTH);

    // term counter covers features plus bias, or hidden values plus bias
    localparam int TERM_CNT_MAX = (HIDDEN_NEURONS + 1 > NUM_FEATURES + 1) ?
                                  HIDDEN_NEURONS + 1 : NUM_FEATURES + 1;
    localparam int TERM_W       = $clog2(TERM_CNT_MAX);
    localparam int HID_IDX_W    = (HIDDEN_NEURONS > 1) ? $clog2(HIDDEN_NEURONS) : 1;

    // weights are trained at 2^14 scale and rounded to FRAC_BITS
    localparam int ROUND_SHIFT = 14 - FRAC_BITS;
    localparam int ROUND_HALF  = (ROUND_SHIFT > 0) ? (1 << (ROUND_SHIFT - 1)) : 0;

    // one tanh table step in lsbs of the hidden and output sums
    localparam int HID_SHIFT = 2 * FRAC_BITS - 2;
    localparam int OUT_SHIFT = 14 + FRAC_BITS;

    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = ((OUT_SHIFT > FEAT_W) ? OUT_SHIFT : FEAT_W) + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 33 + $clog2(HIDDEN_NEURONS + 2);
    localparam int SAT_W   = 32;
    localparam int MAG_W   = 33;
    localparam int HID_W   = 17;
    localparam int TAB_W   = 16;
    localparam int TAB_IDX_W = 5;
    localparam int TAB_LAST  = 16;

    localparam logic signed [MUL_A_W-1:0] HID_ONE = MUL_A_W'(1 << FRAC_BITS);
    localparam logic signed [MUL_A_W-1:0] OUT_ONE = MUL_A_W'(1 << 15);
    localparam logic signed [ACC_W-1:0]   ACC_MAX = ACC_W'(64'sh7fff_ffff);
    localparam logic signed [ACC_W-1:0]   ACC_MIN = ACC_W'(-64'sh8000_0000);
    localparam logic signed [HID_W+1:0]   SCORE_MID = (HID_W + 2)'(32768);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_SAT,
        S_ABS,
        S_INTERP,
        S_TANH
    } state_t;

    localparam int TRAINED_Q14 [TRAINED_COUNT] = '{
        -5873, -6653, 15041, 16267, -7604,
        -8793, -14072, 8228, -14908, -3217,
        -7899, -2426, 1422, 13128, 5370,
        16156, 13794, -4914, 7830, -4281,
        768, 2150, -14014, 7138, 7506,
        -14386, 2496, -16481, -10221, -13658,
        767
    };

    localparam logic [TAB_W-1:0] TANH_TAB [TAB_LAST + 1] = '{
        16'd0, 16'd8025, 16'd15143, 16'd20813, 16'd24956, 16'd27797,
        16'd29660, 16'd30847, 16'd31589, 16'd32048, 16'd32329, 16'd32501,
        16'd32606, 16'd32670, 16'd32708, 16'd32732, 16'd32746
    };

    // read-only weight store, entries past the trained set read as zero
    function automatic logic signed [FEAT_W-1:0] wrom_read(input logic [WIDX_W-1:0] idx);
        int a;
        a = 0;
        if (int'(idx) < TRAINED_COUNT && int'(idx) < WROM_DEPTH) begin
            a = (TRAINED_Q14[idx] + ROUND_HALF) >>> ROUND_SHIFT;
        end
        return FEAT_W'(a);
    endfunction

    function automatic logic [TAB_W-1:0] tanh_tab_read(input logic [TAB_IDX_W-1:0] idx);
        logic [TAB_W-1:0] v;
        v = TANH_TAB[TAB_LAST];
        if (int'(idx) < TAB_LAST) begin
            v = TANH_TAB[idx];
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/mlp_inference_tanh_sigmoid.sv =====
// ----------------------------------------------------------------------------
// mlp scorer core
// 4-5-1 perceptron with tanh hidden layer and sigmoid output on one shared mac
// ----------------------------------------------------------------------------
// One feature request is taken while the core is idle; the core is busy until
// its score is loaded into the output register, which waits while an older
// score is still not taken. All products go through a single
// 17 x 27 bit signed multiplier with a registered product: each hidden neuron
// takes five products (four features and the bias), a drain cycle, saturation,
// magnitude, and table interpolation in an interpolate state that reuses the
// same multiplier and a tanh state; the output neuron takes H+1 products and
// the same tail. The result sits in an output register, so the next request
// can start while the previous score waits to be taken.
`timescale 1ns / 1ps

`include "mlp_inference_tanh_sigmoid_defines.svh"

module mlp_inference_tanh_sigmoid
    import mlp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [FEAT_W-1:0] feat_0,
    input  logic signed [FEAT_W-1:0] feat_1,
    input  logic signed [FEAT_W-1:0] feat_2,
    input  logic signed [FEAT_W-1:0] feat_3,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [15:0]              score,
    output logic                     flap
);

    state_t                 state_reg, state_next;
    logic                   out_phase_reg, out_phase_next;
    logic [TERM_W-1:0]      term_reg, term_next;
    logic [HID_IDX_W-1:0]   neuron_reg, neuron_next;
    logic [WIDX_W-1:0]      widx_reg, widx_next;
    logic                   prod_valid_reg, prod_valid_next;
    logic                   out_valid_reg, out_valid_next;

    logic signed [FEAT_W-1:0]  feat_reg [NUM_FEATURES];
    logic signed [HID_W-1:0]   hid_reg [HIDDEN_NEURONS];
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [SAT_W-1:0]   sat_reg, sat_next;
    logic [MAG_W-1:0]          mag_reg, mag_next;
    logic                      neg_reg, neg_next;
    logic [3:0]                k_reg, k_next;
    logic                      clamp_reg, clamp_next;
    logic [15:0]               score_reg, score_next;
    logic                      flap_reg, flap_next;

    logic                      in_take;
    logic                      hid_we;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [MAG_W-1:0]   sat_ext;
    logic [3:0]                seg_k;
    logic [TAB_W-1:0]          tab_diff;
    logic [TAB_W-1:0]          interp;
    logic [TAB_W-1:0]          y_mag;
    logic signed [HID_W-1:0]   t_val;
    logic signed [HID_W+1:0]   score_sum;
    logic                      last_term;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_take   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign score     = score_reg;
    assign flap      = flap_reg;

    // the shared multiplier
    assign mul_p = mul_a * mul_b;

    assign last_term = out_phase_reg ? (term_reg == TERM_W'(HIDDEN_NEURONS))
                                     : (term_reg == TERM_W'(NUM_FEATURES));

    assign sat_ext  = MAG_W'(sat_reg);
    assign seg_k    = out_phase_reg ? mag_reg[OUT_SHIFT+3:OUT_SHIFT]
                                    : mag_reg[HID_SHIFT+3:HID_SHIFT];
    assign tab_diff = tanh_tab_read({1'b0, seg_k} + TAB_IDX_W'(1)) -
                      tanh_tab_read({1'b0, seg_k});
    assign interp   = out_phase_reg ? prod_reg[OUT_SHIFT+TAB_W-1:OUT_SHIFT]
                                    : prod_reg[HID_SHIFT+TAB_W-1:HID_SHIFT];
    assign y_mag    = clamp_reg ? tanh_tab_read(TAB_IDX_W'(TAB_LAST))
                                : tanh_tab_read({1'b0, k_reg}) + interp;
    assign t_val    = neg_reg ? -HID_W'(y_mag) : HID_W'(y_mag);
    assign score_sum = SCORE_MID + (HID_W + 2)'(t_val);

    always_comb
    begin
        state_next      = state_reg;
        out_phase_next  = out_phase_reg;
        term_next       = term_reg;
        neuron_next     = neuron_reg;
        widx_next       = widx_reg;
        prod_valid_next = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        sat_next        = sat_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        k_next          = k_reg;
        clamp_next      = clamp_reg;
        score_next      = score_reg;
        flap_next       = flap_reg;
        hid_we          = 1'b0;
        mul_a           = '0;
        mul_b           = '0;

        if (prod_valid_reg) begin
            acc_next = acc_reg + ACC_W'(prod_reg[ACC_W-1:0]);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take) begin
                    state_next     = S_MAC;
                    out_phase_next = 1'b0;
                    term_next      = '0;
                    neuron_next    = '0;
                    widx_next      = '0;
                    acc_next       = '0;
                end
            end
            S_MAC:
            begin
                if (out_phase_reg) begin
                    mul_a = (term_reg < TERM_W'(HIDDEN_NEURONS)) ?
                            hid_reg[term_reg[HID_IDX_W-1:0]] : OUT_ONE;
                end else begin
                    mul_a = (term_reg < TERM_W'(NUM_FEATURES)) ?
                            MUL_A_W'(feat_reg[term_reg[1:0]]) : HID_ONE;
                end
                mul_b           = MUL_B_W'(wrom_read(widx_reg));
                prod_next       = mul_p;
                prod_valid_next = 1'b1;
                widx_next       = widx_reg + WIDX_W'(1);
                term_next       = term_reg + TERM_W'(1);
                if (last_term) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_SAT;
            end
            S_SAT:
            begin
                priority if (acc_reg > ACC_MAX) begin
                    sat_next = SAT_W'(ACC_MAX);
                end else if (acc_reg < ACC_MIN) begin
                    sat_next = SAT_W'(ACC_MIN);
                end else begin
                    sat_next = SAT_W'(acc_reg);
                end
                state_next = S_ABS;
            end
            S_ABS:
            begin
                neg_next   = sat_reg[SAT_W-1];
                mag_next   = sat_reg[SAT_W-1] ? MAG_W'(-sat_ext) : MAG_W'(sat_ext);
                state_next = S_INTERP;
            end
            S_INTERP:
            begin
                // segment index and fraction, then slope times fraction
                k_next = seg_k;
                if (out_phase_reg) begin
                    clamp_next = |mag_reg[MAG_W-1:OUT_SHIFT+4];
                    mul_b      = MUL_B_W'(mag_reg[OUT_SHIFT-1:0]);
                end else begin
                    clamp_next = |mag_reg[MAG_W-1:HID_SHIFT+4];
                    mul_b      = MUL_B_W'(mag_reg[HID_SHIFT-1:0]);
                end
                mul_a      = MUL_A_W'(tab_diff);
                prod_next  = mul_p;
                state_next = S_TANH;
            end
            S_TANH:
            begin
                if (!out_phase_reg) begin
                    hid_we    = 1'b1;
                    term_next = '0;
                    acc_next  = '0;
                    state_next = S_MAC;
                    if (neuron_reg == HID_IDX_W'(HIDDEN_NEURONS - 1)) begin
                        out_phase_next = 1'b1;
                    end else begin
                        neuron_next = neuron_reg + HID_IDX_W'(1);
                    end
                end else if (!out_valid_reg || out_ready) begin
                    score_next     = score_sum[15:0];
                    flap_next      = (t_val > 0);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            out_phase_reg  <= 1'b0;
            term_reg       <= '0;
            neuron_reg     <= '0;
            widx_reg       <= '0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            out_phase_reg  <= out_phase_next;
            term_reg       <= term_next;
            neuron_reg     <= neuron_next;
            widx_reg       <= widx_next;
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            feat_reg[0] <= feat_0;
            feat_reg[1] <= feat_1;
            feat_reg[2] <= feat_2;
            feat_reg[3] <= feat_3;
        end
        if (hid_we) begin
            hid_reg[neuron_reg] <= t_val;
        end
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        sat_reg   <= sat_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        k_reg     <= k_next;
        clamp_reg <= clamp_next;
        score_reg <= score_next;
        flap_reg  <= flap_next;
    end

    `MLP_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready,
                    "core took a second request")
    `MLP_ASSERT_IMP(a_widx_range, state_reg == S_MAC, widx_reg < WIDX_W'(WROM_DEPTH),
                    "weight index past store")
    `MLP_ASSERT_IMP(a_hid_terms, (state_reg == S_MAC) && !out_phase_reg,
                    term_reg <= TERM_W'(NUM_FEATURES), "hidden term count overrun")
    `MLP_ASSERT_IMP(a_flap_match, $rose(out_valid), flap == (score > 16'd32768),
                    "flap disagrees with score")

endmodule
